// ----- hdl/triangle_barycentric_pixel_shade_macros.svh -----
// ----------------------------------------------------------------------------
// triangle_barycentric_pixel_shade_macros
// assertion macros shared by the shading pipeline modules
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BARYCENTRIC_PIXEL_SHADE_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_PIXEL_SHADE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define TBPS_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// condition that must hold in the cycle after a trigger
`define TBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tbps_pkg.sv -----
// ----------------------------------------------------------------------------
// tbps_pkg
// widths, word types and constants of the barycentric pixel shading pipeline
// ----------------------------------------------------------------------------
package tbps_pkg;

    localparam int PIXEL_BITS = 10;
    localparam int COORD_BITS = 12;
    localparam int VALUE_BITS = 16;

    // signed width that holds both pixel and vertex coordinates
    localparam int EDGE_BITS  = (COORD_BITS > PIXEL_BITS + 1) ? COORD_BITS : PIXEL_BITS + 1;
    localparam int DIFF_BITS  = EDGE_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    // doubled area magnitude, bounded by the square of the coordinate span
    localparam int AREA_BITS  = 2 * EDGE_BITS;
    localparam int WPROD_BITS = AREA_BITS + 1 + VALUE_BITS;
    localparam int NUM_BITS   = WPROD_BITS + 2;
    localparam int DVD_BITS   = NUM_BITS + 2;
    localparam int DVS_BITS   = AREA_BITS + 1;
    localparam int QUOT_BITS  = VALUE_BITS;
    localparam int REM_BITS   = DVS_BITS + 1;

    localparam logic [QUOT_BITS-1:0] QUOT_HALF = {1'b1, {(QUOT_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // input word: one pixel to shade
    typedef struct packed {
        logic        [PIXEL_BITS-1:0] pixel_x;
        logic        [PIXEL_BITS-1:0] pixel_y;
        logic signed [COORD_BITS-1:0] vertex_a_x;
        logic signed [COORD_BITS-1:0] vertex_a_y;
        logic signed [COORD_BITS-1:0] vertex_b_x;
        logic signed [COORD_BITS-1:0] vertex_b_y;
        logic signed [COORD_BITS-1:0] vertex_c_x;
        logic signed [COORD_BITS-1:0] vertex_c_y;
        logic signed [VALUE_BITS-1:0] color_a;
        logic signed [VALUE_BITS-1:0] color_b;
        logic signed [VALUE_BITS-1:0] color_c;
        logic signed [VALUE_BITS-1:0] old_value;
    } pixel_word_t;

    // output word: shaded pixel
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] new_value;
        logic                         covered;
    } shade_word_t;

    // colors and old value carried alongside the area math
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] color_a;
        logic signed [VALUE_BITS-1:0] color_b;
        logic signed [VALUE_BITS-1:0] color_c;
        logic signed [VALUE_BITS-1:0] old_value;
    } color_side_t;

    // doubled areas of the three sub-triangles and the whole triangle
    typedef struct packed {
        logic [AREA_BITS-1:0] area_1;
        logic [AREA_BITS-1:0] area_2;
        logic [AREA_BITS-1:0] area_3;
        logic [AREA_BITS-1:0] area_all;
        color_side_t          side;
    } area_word_t;

    // divider operands with the sign and coverage of the item
    typedef struct packed {
        logic [DVD_BITS-1:0]          dvd;
        logic [DVS_BITS-1:0]          dvs;
        logic                         neg;
        logic                         hit;
        logic signed [VALUE_BITS-1:0] old_value;
    } div_in_t;

    // one stage of the restoring divider
    typedef struct packed {
        logic [DVS_BITS-1:0]          rem;
        logic [QUOT_BITS-1:0]         low;
        logic [QUOT_BITS-1:0]         quot;
        logic [DVS_BITS-1:0]          dvs;
        logic                         neg;
        logic                         hit;
        logic signed [VALUE_BITS-1:0] old_value;
    } div_stage_t;

endpackage

// ----- hdl/tbps_area.sv -----
// ----------------------------------------------------------------------------
// tbps_area
// three-stage pipeline forming the doubled absolute sub-triangle areas
// ----------------------------------------------------------------------------
module tbps_area
    import tbps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  pixel_word_t in_word,
    output logic        out_valid,
    output area_word_t  out_word
);

    logic [2:0] valid_reg;

    // stage 1 registers: vertex minus pixel, and edges from vertex a
    logic signed [DIFF_BITS-1:0] dp_reg [6];
    logic signed [DIFF_BITS-1:0] de_reg [4];
    color_side_t                 side1_reg;

    // stage 2 registers: cross product halves
    logic signed [PROD_BITS-1:0] prod_l_reg [4];
    logic signed [PROD_BITS-1:0] prod_r_reg [4];
    color_side_t                 side2_reg;

    // stage 3 registers
    area_word_t area_reg;

    logic signed [EDGE_BITS-1:0] px, py;
    logic signed [EDGE_BITS-1:0] vx [3];
    logic signed [EDGE_BITS-1:0] vy [3];
    logic signed [DIFF_BITS-1:0] dp_next [6];
    logic signed [DIFF_BITS-1:0] de_next [4];
    logic signed [PROD_BITS-1:0] prod_l_next [4];
    logic signed [PROD_BITS-1:0] prod_r_next [4];
    logic        [AREA_BITS-1:0] abs_next [4];
    logic signed [PROD_BITS:0]   xprod [4];

    // coordinate differences
    always_comb
    begin
        px = signed'(EDGE_BITS'({1'b0, in_word.pixel_x}));
        py = signed'(EDGE_BITS'({1'b0, in_word.pixel_y}));
        vx[0] = EDGE_BITS'(in_word.vertex_a_x);
        vy[0] = EDGE_BITS'(in_word.vertex_a_y);
        vx[1] = EDGE_BITS'(in_word.vertex_b_x);
        vy[1] = EDGE_BITS'(in_word.vertex_b_y);
        vx[2] = EDGE_BITS'(in_word.vertex_c_x);
        vy[2] = EDGE_BITS'(in_word.vertex_c_y);
        for (int i = 0; i < 3; i++)
        begin
            dp_next[2*i]   = DIFF_BITS'(vx[i]) - DIFF_BITS'(px);
            dp_next[2*i+1] = DIFF_BITS'(vy[i]) - DIFF_BITS'(py);
        end
        de_next[0] = DIFF_BITS'(vx[1]) - DIFF_BITS'(vx[0]);
        de_next[1] = DIFF_BITS'(vy[1]) - DIFF_BITS'(vy[0]);
        de_next[2] = DIFF_BITS'(vx[2]) - DIFF_BITS'(vx[0]);
        de_next[3] = DIFF_BITS'(vy[2]) - DIFF_BITS'(vy[0]);
    end

    // products: (p,a,b), (p,b,c), (p,c,a), (a,b,c)
    always_comb
    begin
        prod_l_next[0] = PROD_BITS'(dp_reg[0]) * PROD_BITS'(dp_reg[3]);
        prod_r_next[0] = PROD_BITS'(dp_reg[1]) * PROD_BITS'(dp_reg[2]);
        prod_l_next[1] = PROD_BITS'(dp_reg[2]) * PROD_BITS'(dp_reg[5]);
        prod_r_next[1] = PROD_BITS'(dp_reg[3]) * PROD_BITS'(dp_reg[4]);
        prod_l_next[2] = PROD_BITS'(dp_reg[4]) * PROD_BITS'(dp_reg[1]);
        prod_r_next[2] = PROD_BITS'(dp_reg[5]) * PROD_BITS'(dp_reg[0]);
        prod_l_next[3] = PROD_BITS'(de_reg[0]) * PROD_BITS'(de_reg[3]);
        prod_r_next[3] = PROD_BITS'(de_reg[1]) * PROD_BITS'(de_reg[2]);
    end

    // cross product and magnitude
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            xprod[i] = (PROD_BITS+1)'(prod_l_reg[i]) - (PROD_BITS+1)'(prod_r_reg[i]);
            abs_next[i] = xprod[i][PROD_BITS] ? AREA_BITS'(-xprod[i])
                                              : AREA_BITS'(xprod[i]);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dp_reg <= dp_next;
            de_reg <= de_next;
            side1_reg.color_a   <= in_word.color_a;
            side1_reg.color_b   <= in_word.color_b;
            side1_reg.color_c   <= in_word.color_c;
            side1_reg.old_value <= in_word.old_value;
            prod_l_reg <= prod_l_next;
            prod_r_reg <= prod_r_next;
            side2_reg  <= side1_reg;
            area_reg.area_1   <= abs_next[0];
            area_reg.area_2   <= abs_next[1];
            area_reg.area_3   <= abs_next[2];
            area_reg.area_all <= abs_next[3];
            area_reg.side     <= side2_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_word  = area_reg;

endmodule

// ----- hdl/tbps_blend.sv -----
// ----------------------------------------------------------------------------
// tbps_blend
// coverage test, area-weighted color sum and divider operand setup
// ----------------------------------------------------------------------------
module tbps_blend
    import tbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       in_valid,
    input  area_word_t in_word,
    output logic       out_valid,
    output div_in_t    out_word
);

    logic [2:0] valid_reg;

    // stage 4 registers
    logic signed [WPROD_BITS-1:0] wprod_reg [3];
    logic        [AREA_BITS-1:0]  area4_reg;
    logic                         hit4_reg;
    logic signed [VALUE_BITS-1:0] old4_reg;

    // stage 5 registers
    logic signed [NUM_BITS-1:0]   num_reg;
    logic        [AREA_BITS-1:0]  area5_reg;
    logic                         hit5_reg;
    logic signed [VALUE_BITS-1:0] old5_reg;

    // stage 6 register
    div_in_t div_reg;

    logic        [AREA_BITS+1:0]  area_sum;
    logic                         hit_next;
    logic signed [WPROD_BITS-1:0] wprod_next [3];
    logic signed [NUM_BITS-1:0]   num_next;
    logic        [NUM_BITS-1:0]   mag;
    div_in_t                      div_next;

    // coverage and weighted products
    always_comb
    begin
        area_sum = (AREA_BITS+2)'(in_word.area_1) + (AREA_BITS+2)'(in_word.area_2)
                 + (AREA_BITS+2)'(in_word.area_3);
        hit_next = (in_word.area_all != '0)
                && (area_sum <= (AREA_BITS+2)'(in_word.area_all));
        wprod_next[0] = WPROD_BITS'(signed'({1'b0, in_word.area_1}))
                      * WPROD_BITS'(in_word.side.color_c);
        wprod_next[1] = WPROD_BITS'(signed'({1'b0, in_word.area_2}))
                      * WPROD_BITS'(in_word.side.color_a);
        wprod_next[2] = WPROD_BITS'(signed'({1'b0, in_word.area_3}))
                      * WPROD_BITS'(in_word.side.color_b);
    end

    // weighted sum
    assign num_next = NUM_BITS'(wprod_reg[0]) + NUM_BITS'(wprod_reg[1])
                    + NUM_BITS'(wprod_reg[2]);

    // sign-magnitude and rounding offset: q = (2|num| + a) / 2a
    always_comb
    begin
        mag = num_reg[NUM_BITS-1] ? NUM_BITS'(-num_reg) : NUM_BITS'(num_reg);
        div_next.dvd       = (DVD_BITS'(mag) << 1) + DVD_BITS'(area5_reg);
        div_next.dvs       = DVS_BITS'(area5_reg) << 1;
        div_next.neg       = num_reg[NUM_BITS-1];
        div_next.hit       = hit5_reg;
        div_next.old_value = old5_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wprod_reg <= wprod_next;
            area4_reg <= in_word.area_all;
            hit4_reg  <= hit_next;
            old4_reg  <= in_word.side.old_value;
            num_reg   <= num_next;
            area5_reg <= area4_reg;
            hit5_reg  <= hit4_reg;
            old5_reg  <= old4_reg;
            div_reg   <= div_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_word  = div_reg;

endmodule

// ----- hdl/tbps_div.sv -----
// ----------------------------------------------------------------------------
// tbps_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tbps_div
    import tbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       in_valid,
    input  div_in_t    in_word,
    output logic       out_valid,
    output div_stage_t out_word
);

`include "triangle_barycentric_pixel_shade_macros.svh"

    logic [QUOT_BITS-1:0] valid_reg;
    div_stage_t           stage_reg  [QUOT_BITS];
    div_stage_t           stage_next [QUOT_BITS];
    div_stage_t           first;

    // initial partial remainder: the dividend bits above the quotient field
    always_comb
    begin
        first.rem       = DVS_BITS'(in_word.dvd[DVD_BITS-1:QUOT_BITS]);
        first.low       = in_word.dvd[QUOT_BITS-1:0];
        first.quot      = '0;
        first.dvs       = in_word.dvs;
        first.neg       = in_word.neg;
        first.hit       = in_word.hit;
        first.old_value = in_word.old_value;
    end

    // one compare-subtract per stage
    for (genvar k = 0; k < QUOT_BITS; k++)
    begin : g_step
        div_stage_t          src;
        div_stage_t          nxt;
        logic [REM_BITS-1:0] trial;
        logic [REM_BITS-1:0] diff;
        logic                qbit;

        if (k == 0)
        begin : g_head
            assign src = first;
        end
        else
        begin : g_body
            assign src = stage_reg[k-1];
        end

        always_comb
        begin
            trial = {src.rem, src.low[QUOT_BITS-1]};
            diff  = trial - {1'b0, src.dvs};
            qbit  = (trial >= {1'b0, src.dvs});
            nxt           = src;
            nxt.rem       = qbit ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
            nxt.low       = src.low << 1;
            nxt.quot      = {src.quot[QUOT_BITS-2:0], qbit};
        end

        assign stage_next[k] = nxt;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[QUOT_BITS-2:0], in_valid};
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < QUOT_BITS; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign out_valid = valid_reg[QUOT_BITS-1];
    assign out_word  = stage_reg[QUOT_BITS-1];

    // remainder stays below the divisor for covered pixels
    `TBPS_ASSERT_HOLD(a_rem_first, valid_reg[0] && stage_reg[0].hit |-> stage_reg[0].rem < stage_reg[0].dvs, "first remainder not below divisor")
    `TBPS_ASSERT_HOLD(a_rem_last, out_valid && out_word.hit |-> out_word.rem < out_word.dvs, "last remainder not below divisor")
    // divisor is twice the area
    `TBPS_ASSERT_HOLD(a_dvs_even, valid_reg[0] |-> stage_reg[0].dvs[0] == 1'b0, "odd divisor")

endmodule

// ----- hdl/triangle_barycentric_pixel_shade.sv -----
// ----------------------------------------------------------------------------
// triangle_barycentric_pixel_shade
// per-pixel triangle coverage test and barycentric color interpolation
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and returns one shade word per pixel, in
// order: three stages form the doubled sub-triangle areas, three more do
// the coverage test, the weighted color sum and the rounding offset, one
// stage per quotient bit runs the restoring divider, and the last stage
// applies the sign, saturates and holds the output word. The throughput
// is one pixel per clock while the output is not stalled; a stall on the
// output freezes the whole pipeline, which is fed again as soon as the
// output word is taken.
module triangle_barycentric_pixel_shade
    import tbps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_ready,
    input  pixel_word_t pixel_word,
    output logic        shade_valid,
    input  logic        shade_ready,
    output shade_word_t shade_word
);

`include "triangle_barycentric_pixel_shade_macros.svh"

    logic        adv;
    logic        area_valid;
    area_word_t  area_out;
    logic        blend_valid;
    div_in_t     blend_out;
    logic        div_valid;
    div_stage_t  div_out;
    logic        out_valid_reg;
    shade_word_t out_reg;
    shade_word_t out_next;
    logic [VALUE_BITS-1:0] shaded;

    // whole pipeline moves when the output word is free or taken
    assign adv         = !out_valid_reg || shade_ready;
    assign pixel_ready = adv;

    tbps_area u_area (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pixel_valid),
        .in_word   (pixel_word),
        .out_valid (area_valid),
        .out_word  (area_out)
    );

    tbps_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (area_valid),
        .in_word   (area_out),
        .out_valid (blend_valid),
        .out_word  (blend_out)
    );

    tbps_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (blend_valid),
        .in_word   (blend_out),
        .out_valid (div_valid),
        .out_word  (div_out)
    );

    // sign, saturation and outside pass-through
    always_comb
    begin
        if (div_out.neg)
        begin
            shaded = (div_out.quot > QUOT_HALF) ? VALUE_MIN
                                                : VALUE_BITS'(~div_out.quot + 1'b1);
        end
        else
        begin
            shaded = (div_out.quot > QUOT_BITS'(VALUE_MAX)) ? VALUE_MAX
                                                            : VALUE_BITS'(div_out.quot);
        end
        out_next.new_value = div_out.hit ? signed'(shaded) : div_out.old_value;
        out_next.covered   = div_out.hit;
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign shade_valid = out_valid_reg;
    assign shade_word  = out_reg;

    // a covered pixel averages its colors, so the quotient stays in range
    `TBPS_ASSERT_HOLD(a_quot_range, div_valid && div_out.hit |-> div_out.quot <= QUOT_HALF, "quotient out of range for covered pixel")
    // coverage never comes from a degenerate triangle
    `TBPS_ASSERT_HOLD(a_hit_area, div_valid && div_out.hit |-> div_out.dvs != '0, "covered pixel with zero area")
    // a stalled output holds the divider tail
    `TBPS_ASSERT_NEXT(a_stall_freeze, !adv && div_valid, div_valid && $stable(div_out), "divider moved during stall")

endmodule
